/* hdl/rceh_pkg.sv */
// ----------------------------------------------------------------------------
// rceh_pkg - shared types and constants
// Word formats, tracker command codes and queue sizing for the report
// control event handler.
// ----------------------------------------------------------------------------
package rceh_pkg;

   localparam int BRIGHT_W    = 8;
   localparam int BRIGHT_OUT_W = 7;
   localparam int PAGE_W      = 3;
   localparam int CMD_W       = 2;
   localparam int THRESH_W    = 16;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd500;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE  = 2'd0,
      CMD_PAUSE = 2'd1,
      CMD_RESET = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      SCROLL_IDLE = 2'b00,
      SCROLL_DOWN = 2'b01,
      SCROLL_UP   = 2'b10,
      SCROLL_BOTH = 2'b11
   } scroll_type;

   // classified item handed from front to back
   typedef struct packed {
      logic                    is_tick;
      logic                    connected;
      logic                    bright_present;
      logic [BRIGHT_OUT_W-1:0] bright_half;
      logic                    scroll_present;
      scroll_type              scroll_code;
      logic                    button_valid;
      logic                    button_now;
   } op_type;

   typedef struct packed {
      logic                    brightness_valid;
      logic [BRIGHT_OUT_W-1:0] brightness_value;
      logic                    page_changed;
      logic [PAGE_W-1:0]       page_number;
      cmd_type                 tracker_command;
   } result_type;

endpackage

/* hdl/rceh_if.sv */
// ----------------------------------------------------------------------------
// rceh_if - request and response channel interfaces
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface rceh_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [rceh_pkg::BRIGHT_W-1:0] brightness_byte;
   logic brightness_present;
   logic scroll_down;
   logic scroll_up;
   logic scroll_present;
   logic button_pressed;
   logic buttons_present;
   logic tracker_connected;

   modport source (
      output valid, action, brightness_byte, brightness_present, scroll_down,
             scroll_up, scroll_present, button_pressed, buttons_present,
             tracker_connected,
      input  ready
   );
   modport sink (
      input  valid, action, brightness_byte, brightness_present, scroll_down,
             scroll_up, scroll_present, button_pressed, buttons_present,
             tracker_connected,
      output ready
   );
endinterface

interface rceh_rsp_if;
   logic valid;
   logic ready;
   logic brightness_valid;
   logic [rceh_pkg::BRIGHT_OUT_W-1:0] brightness_value;
   logic page_changed;
   logic [rceh_pkg::PAGE_W-1:0] page_number;
   logic [rceh_pkg::CMD_W-1:0] tracker_command;

   modport source (
      output valid, brightness_valid, brightness_value, page_changed,
             page_number, tracker_command,
      input  ready
   );
   modport sink (
      input  valid, brightness_valid, brightness_value, page_changed,
             page_number, tracker_command,
      output ready
   );
endinterface

/* hdl/rceh_front.sv */
// ----------------------------------------------------------------------------
// rceh_front - input word classifier
// Accepts request words and reduces them to the operation the back end
// executes: halved brightness, scroll code and button event qualifiers.
// ----------------------------------------------------------------------------
module rceh_front (
   rceh_req_if.sink         req,
   output logic             op_valid,
   input  logic             op_ready,
   output rceh_pkg::op_type op
);

   logic is_tick;

   assign is_tick  = req.action;
   assign op_valid = req.valid;
   assign req.ready = op_ready;

   always_comb begin
      op                = '0;
      op.is_tick        = is_tick;
      op.connected      = req.tracker_connected;
      op.bright_present = !is_tick && req.brightness_present;
      op.bright_half    = req.brightness_byte[rceh_pkg::BRIGHT_W-1:1];
      op.scroll_present = !is_tick && req.scroll_present;
      op.scroll_code    = rceh_pkg::scroll_type'({req.scroll_up, req.scroll_down});
      op.button_valid   = !is_tick && req.tracker_connected && req.buttons_present;
      op.button_now     = req.button_pressed;
   end

endmodule

/* hdl/rceh_queue.sv */
// ----------------------------------------------------------------------------
// rceh_queue - operation queue
// Two-entry FIFO between classifier and executor.
// ----------------------------------------------------------------------------
module rceh_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rceh_pkg::op_type push_op,
   output logic             pop_valid,
   input  logic             pop_ready,
   output rceh_pkg::op_type pop_op
);

   rceh_pkg::op_type                    store_ff [rceh_pkg::QUEUE_DEPTH];
   logic [rceh_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rceh_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rceh_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                push, pop;

   assign push_ready = count_ff != rceh_pkg::QUEUE_CNT_W'(rceh_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = store_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rceh_pkg::QUEUE_PTR_W'(rceh_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == rceh_pkg::QUEUE_PTR_W'(rceh_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

/* hdl/rceh_back.sv */
// ----------------------------------------------------------------------------
// rceh_back - event executor
// Applies brightness, page and button-timer state updates for each queued
// operation and holds the result word in an output register.
// ----------------------------------------------------------------------------
module rceh_back #(
   parameter int PAGE_COUNT        = 5,
   parameter int TICK_COUNTER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rceh_pkg::THRESH_W-1:0]       csr_write_data,
   input  logic                                op_valid,
   output logic                                op_ready,
   input  rceh_pkg::op_type                    op,
   rceh_rsp_if.source                          rsp
);

   localparam int CMP_W = (TICK_COUNTER_BITS > rceh_pkg::THRESH_W) ?
                          TICK_COUNTER_BITS : rceh_pkg::THRESH_W;
   localparam logic [rceh_pkg::PAGE_W-1:0] PAGE_LAST = rceh_pkg::PAGE_W'(PAGE_COUNT - 1);

   logic [rceh_pkg::THRESH_W-1:0]  thresh_ff;
   logic [rceh_pkg::BRIGHT_W-1:0]  last_bright_ff, last_bright_in;
   logic [rceh_pkg::PAGE_W-1:0]    page_ff, page_in;
   rceh_pkg::scroll_type           scroll_prev_ff, scroll_prev_in;
   logic                           button_prev_ff, button_prev_in;
   logic                           handled_ff, handled_in;
   logic [TICK_COUNTER_BITS-1:0]   ticks_ff, ticks_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rceh_pkg::result_type           rsp_ff, rsp_in;

   logic                           take;
   logic [TICK_COUNTER_BITS-1:0]   ticks_bumped;
   logic                           due_now, due_bumped;

   assign op_ready = !rsp_valid_ff || rsp.ready;
   assign take     = op_valid && op_ready;

   always_comb begin
      ticks_bumped = ticks_ff;
      if (button_prev_ff && !handled_ff && (ticks_ff != '1)) begin
         ticks_bumped = ticks_ff + 1'b1;
      end
   end

   assign due_now    = CMP_W'(ticks_ff) >= CMP_W'(thresh_ff);
   assign due_bumped = CMP_W'(ticks_bumped) >= CMP_W'(thresh_ff);

   always_comb begin
      last_bright_in = last_bright_ff;
      page_in        = page_ff;
      scroll_prev_in = scroll_prev_ff;
      button_prev_in = button_prev_ff;
      handled_in     = handled_ff;
      ticks_in       = ticks_ff;
      rsp_in         = '0;
      rsp_in.tracker_command = rceh_pkg::CMD_NONE;

      if (op.is_tick) begin
         ticks_in = ticks_bumped;
         if (op.connected && button_prev_ff && !handled_ff && due_bumped) begin
            handled_in = 1'b1;
            rsp_in.tracker_command = rceh_pkg::CMD_PAUSE;
         end
      end else begin
         if (op.bright_present &&
             ({1'b0, op.bright_half} != last_bright_ff)) begin
            last_bright_in = {1'b0, op.bright_half};
            rsp_in.brightness_valid = 1'b1;
            rsp_in.brightness_value = op.bright_half;
         end
         if (op.scroll_present) begin
            if ((op.scroll_code != rceh_pkg::SCROLL_IDLE) &&
                (scroll_prev_ff == rceh_pkg::SCROLL_IDLE)) begin
               if (op.scroll_code == rceh_pkg::SCROLL_DOWN) begin
                  page_in = (page_ff == PAGE_LAST) ? '0 : page_ff + 1'b1;
               end else begin
                  page_in = (page_ff == '0) ? PAGE_LAST : page_ff - 1'b1;
               end
               rsp_in.page_changed = 1'b1;
            end
            scroll_prev_in = op.scroll_code;
         end
         if (op.button_valid) begin
            if (op.button_now && !button_prev_ff) begin
               ticks_in   = '0;
               handled_in = 1'b0;
            end else if (op.button_now && !handled_ff) begin
               if (due_now) begin
                  handled_in = 1'b1;
                  rsp_in.tracker_command = rceh_pkg::CMD_PAUSE;
               end
            end else if (!op.button_now && button_prev_ff) begin
               if (!handled_ff) begin
                  rsp_in.tracker_command = rceh_pkg::CMD_RESET;
               end
            end
            button_prev_in = op.button_now;
         end
      end
      rsp_in.page_number = page_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff      <= rceh_pkg::THRESH_RESET;
         last_bright_ff <= '1;
         page_ff        <= '0;
         scroll_prev_ff <= rceh_pkg::SCROLL_IDLE;
         button_prev_ff <= 1'b0;
         handled_ff     <= 1'b0;
         ticks_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            thresh_ff <= csr_write_data;
         end
         if (take) begin
            last_bright_ff <= last_bright_in;
            page_ff        <= page_in;
            scroll_prev_ff <= scroll_prev_in;
            button_prev_ff <= button_prev_in;
            handled_ff     <= handled_in;
            ticks_ff       <= ticks_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.brightness_valid = rsp_ff.brightness_valid;
   assign rsp.brightness_value = rsp_ff.brightness_value;
   assign rsp.page_changed     = rsp_ff.page_changed;
   assign rsp.page_number      = rsp_ff.page_number;
   assign rsp.tracker_command  = rsp_ff.tracker_command;

endmodule

/* hdl/report_control_event_handler_unit.sv */
// ----------------------------------------------------------------------------
// report_control_event_handler_unit - controller report and tick handler
// Turns controller reports and time ticks into brightness, page and
// tracker pause/reset commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one word per controller report (action 0) or time tick
//   (action 1); rsp_bus returns exactly one result word per request word, in
//   order. csr_write_data is loaded into the long-press threshold on any
//   clock with csr_write_enable high; write it only while the unit is idle.
//   Throughput: one word per cycle while rsp_bus is ready. A word is written
//   into the two-entry queue when accepted, and the result register is loaded
//   at the edge where the word leaves the queue.
//   The rate is set by the executor, which updates its per-word state as it takes each word.
//   Reset (synchronous): queue emptied, threshold 500, page 0, brightness
//   marked as never sent, scroll and button history cleared.
//   When rsp_bus stalls, the executor holds its result and the queue
//   absorbs up to two more words before req_bus.ready drops.
// ----------------------------------------------------------------------------
module report_control_event_handler_unit #(
   parameter int PAGE_COUNT        = 5,
   parameter int TICK_COUNTER_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [rceh_pkg::THRESH_W-1:0] csr_write_data,
   rceh_req_if.sink                      req_bus,
   rceh_rsp_if.source                    rsp_bus
);

   logic             front_valid, front_ready;
   rceh_pkg::op_type front_op;
   logic             back_valid, back_ready;
   rceh_pkg::op_type back_op;

   rceh_front u_front (
      .req      (req_bus),
      .op_valid (front_valid),
      .op_ready (front_ready),
      .op       (front_op)
   );

   rceh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_op    (front_op),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_op     (back_op)
   );

   rceh_back #(
      .PAGE_COUNT        (PAGE_COUNT),
      .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .op_valid         (back_valid),
      .op_ready         (back_ready),
      .op               (back_op),
      .rsp              (rsp_bus)
   );

endmodule
